// ----- src/gwps_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the grid word path search core.
// No dependencies; every other file imports this package.
package gwps_pkg;

    // Sizes of the stores
    localparam int MAX_ROWS = 16;
    localparam int MAX_COLS = 16;
    localparam int MAX_WORD = 16;
    localparam int CELLS    = MAX_ROWS * MAX_COLS;

    // Field widths of the channels
    localparam int KIND_W    = 2;
    localparam int ROW_FW    = 4;
    localparam int COL_FW    = 4;
    localparam int POS_FW    = 4;
    localparam int CHAR_W    = 8;
    localparam int CFG_W     = 5;
    localparam int REG_IDX_W = 2;

    // Internal widths
    localparam int ROW_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int CELL_W  = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int DIDX_W  = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;
    localparam int RCNT_W  = $clog2(MAX_ROWS + 1);
    localparam int CCNT_W  = $clog2(MAX_COLS + 1);
    localparam int DEPTH_W = $clog2(MAX_WORD + 1);

    typedef enum logic [KIND_W-1:0] {
        KIND_GRID  = 2'd0,
        KIND_WORD  = 2'd1,
        KIND_START = 2'd2
    } kind_t;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_GRID_ROWS   = 2'd0,
        REG_GRID_COLS   = 2'd1,
        REG_WORD_LENGTH = 2'd2
    } reg_idx_t;

    // Next direction to try from a stack entry; DIR_DONE means all four tried
    typedef enum logic [2:0] {
        DIR_DOWN  = 3'd0,
        DIR_UP    = 3'd1,
        DIR_RIGHT = 3'd2,
        DIR_LEFT  = 3'd3,
        DIR_DONE  = 3'd4
    } dir_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_STEP,
        ST_NB_CHK,
        ST_DONE_HIT,
        ST_DONE_MISS
    } state_t;

    typedef struct packed {
        logic load_grid;
        logic load_word;
        logic scan_init;
        logic scan_read;
        logic scan_next;
        logic push_start;
        logic step;
        logic pop;
        logic push_nb;
        logic clear_depth;
        logic post;
        logic post_found;
    } cmd_t;

    typedef struct packed {
        logic size_zero;
        logic scan_match;
        logic scan_last;
        logic depth_hit;
        logic depth_zero;
        logic dir_done;
        logic nb_ok;
        logic nb_match;
        logic out_full;
    } status_t;

endpackage

// ----- src/gwps_if.sv -----
`timescale 1ns / 1ps
// Channel interfaces: input items, result items and register writes.
// Depends on gwps_pkg.
interface gwps_item_if;
    import gwps_pkg::*;
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [ROW_FW-1:0] row;
    logic [COL_FW-1:0] col;
    logic [POS_FW-1:0] position;
    logic [CHAR_W-1:0] char_value;

    modport source (output valid, kind, row, col, position, char_value, input ready);
    modport sink   (input valid, kind, row, col, position, char_value, output ready);
endinterface

interface gwps_result_if;
    logic valid;
    logic ready;
    logic found;

    modport source (output valid, found, input ready);
    modport sink   (input valid, found, output ready);
endinterface

interface gwps_cfg_if;
    import gwps_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [REG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/gwps_datapath.sv -----
`timescale 1ns / 1ps
// Datapath: registers, grid memory, word store, path stack, scan position,
// neighbor logic and result register. Depends on gwps_pkg and gwps_if.
module gwps_datapath (
    input  logic                      clk,
    input  logic                      rst_n,
    input  gwps_pkg::cmd_t            cmd,
    output gwps_pkg::status_t         status,
    input  logic [gwps_pkg::ROW_FW-1:0] load_row,
    input  logic [gwps_pkg::COL_FW-1:0] load_col,
    input  logic [gwps_pkg::POS_FW-1:0] load_position,
    input  logic [gwps_pkg::CHAR_W-1:0] load_char,
    gwps_cfg_if.sink                  cfg,
    gwps_result_if.source             result
);
    import gwps_pkg::*;

    // Configuration registers
    logic [CFG_W-1:0] rows_cfg_reg, rows_cfg_next;
    logic [CFG_W-1:0] cols_cfg_reg, cols_cfg_next;
    logic [CFG_W-1:0] len_cfg_reg,  len_cfg_next;
    logic [RCNT_W-1:0]  rows_eff;
    logic [CCNT_W-1:0]  cols_eff;
    logic [DEPTH_W-1:0] len_eff;

    // Stores
    logic [CHAR_W-1:0] grid_mem [CELLS];
    logic [CHAR_W-1:0] grid_rd_reg;
    logic [CHAR_W-1:0] word_reg [MAX_WORD];

    // Path stack
    logic [ROW_W-1:0]   stk_row_reg [MAX_WORD];
    logic [COL_W-1:0]   stk_col_reg [MAX_WORD];
    dir_t               stk_dir_reg [MAX_WORD];
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic [DIDX_W-1:0]  top_idx;
    logic [DIDX_W-1:0]  push_idx;
    logic [ROW_W-1:0]   top_row;
    logic [COL_W-1:0]   top_col;
    dir_t               top_dir;

    // Scan position and latched neighbor
    logic [ROW_W-1:0] scan_row_reg, scan_row_next;
    logic [COL_W-1:0] scan_col_reg, scan_col_next;
    logic [ROW_W-1:0] nb_row, nb_row_reg;
    logic [COL_W-1:0] nb_col, nb_col_reg;
    logic             nb_exists;
    logic             nb_visited;
    logic             scan_col_last;
    logic             scan_row_last;

    // Memory access
    logic              load_ok;
    logic [CELL_W-1:0] wr_addr;
    logic [CELL_W-1:0] rd_addr;
    logic              rd_en;

    // Result register
    logic res_valid_reg, res_valid_next;
    logic found_reg,     found_next;

    // ---------------- configuration ----------------
    assign cfg.ready = 1'b1;

    always_comb
    begin
        rows_cfg_next = rows_cfg_reg;
        cols_cfg_next = cols_cfg_reg;
        len_cfg_next  = len_cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_GRID_ROWS:   rows_cfg_next = cfg.data;
                REG_GRID_COLS:   cols_cfg_next = cfg.data;
                REG_WORD_LENGTH: len_cfg_next  = cfg.data;
                default:         ;
            endcase
        end
    end

    // Saturate to the store sizes
    always_comb
    begin
        if (int'(rows_cfg_reg) > MAX_ROWS) rows_eff = RCNT_W'(MAX_ROWS);
        else                               rows_eff = RCNT_W'(rows_cfg_reg);
        if (int'(cols_cfg_reg) > MAX_COLS) cols_eff = CCNT_W'(MAX_COLS);
        else                               cols_eff = CCNT_W'(cols_cfg_reg);
        if (int'(len_cfg_reg) > MAX_WORD)  len_eff  = DEPTH_W'(MAX_WORD);
        else                               len_eff  = DEPTH_W'(len_cfg_reg);
    end

    // ---------------- stack top and neighbor ----------------
    assign top_idx  = DIDX_W'(depth_reg - DEPTH_W'(1));
    assign push_idx = DIDX_W'(depth_reg);
    assign top_row  = stk_row_reg[top_idx];
    assign top_col  = stk_col_reg[top_idx];
    assign top_dir  = stk_dir_reg[top_idx];

    always_comb
    begin
        nb_row    = top_row;
        nb_col    = top_col;
        nb_exists = 1'b0;
        case (top_dir)
            DIR_DOWN:
            begin
                nb_exists = (int'(top_row) + 1) < int'(rows_eff);
                nb_row    = top_row + ROW_W'(1);
            end
            DIR_UP:
            begin
                nb_exists = (top_row != '0);
                nb_row    = top_row - ROW_W'(1);
            end
            DIR_RIGHT:
            begin
                nb_exists = (int'(top_col) + 1) < int'(cols_eff);
                nb_col    = top_col + COL_W'(1);
            end
            DIR_LEFT:
            begin
                nb_exists = (top_col != '0);
                nb_col    = top_col - COL_W'(1);
            end
            default: nb_exists = 1'b0;
        endcase
    end

    // A cell is visited exactly when it sits on the live part of the stack
    always_comb
    begin
        nb_visited = 1'b0;
        for (int i = 0; i < MAX_WORD; i++)
        begin
            if ((i < int'(depth_reg)) && (stk_row_reg[i] == nb_row) &&
                (stk_col_reg[i] == nb_col))
                nb_visited = 1'b1;
        end
    end

    // ---------------- scan position ----------------
    assign scan_col_last = (int'(scan_col_reg) == int'(cols_eff) - 1);
    assign scan_row_last = (int'(scan_row_reg) == int'(rows_eff) - 1);

    always_comb
    begin
        scan_row_next = scan_row_reg;
        scan_col_next = scan_col_reg;
        if (cmd.scan_init)
        begin
            scan_row_next = '0;
            scan_col_next = '0;
        end
        else if (cmd.scan_next)
        begin
            if (scan_col_last)
            begin
                scan_col_next = '0;
                scan_row_next = scan_row_reg + ROW_W'(1);
            end
            else
                scan_col_next = scan_col_reg + COL_W'(1);
        end
    end

    // ---------------- depth ----------------
    always_comb
    begin
        depth_next = depth_reg;
        if (cmd.push_start)
            depth_next = DEPTH_W'(1);
        else if (cmd.push_nb)
            depth_next = depth_reg + DEPTH_W'(1);
        else if (cmd.pop)
            depth_next = depth_reg - DEPTH_W'(1);
        else if (cmd.clear_depth)
            depth_next = '0;
    end

    // ---------------- result register ----------------
    always_comb
    begin
        res_valid_next = res_valid_reg;
        found_next     = found_reg;
        if (cmd.post)
        begin
            res_valid_next = 1'b1;
            found_next     = cmd.post_found;
        end
        else if (result.ready)
            res_valid_next = 1'b0;
    end

    assign result.valid = res_valid_reg;
    assign result.found = found_reg;

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_cfg_reg  <= CFG_W'(1);
            cols_cfg_reg  <= CFG_W'(1);
            len_cfg_reg   <= CFG_W'(1);
            depth_reg     <= '0;
            scan_row_reg  <= '0;
            scan_col_reg  <= '0;
            res_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
        end
        else
        begin
            rows_cfg_reg  <= rows_cfg_next;
            cols_cfg_reg  <= cols_cfg_next;
            len_cfg_reg   <= len_cfg_next;
            depth_reg     <= depth_next;
            scan_row_reg  <= scan_row_next;
            scan_col_reg  <= scan_col_next;
            res_valid_reg <= res_valid_next;
            found_reg     <= found_next;
        end
    end

    // ---------------- stack and neighbor latch ----------------
    always_ff @(posedge clk)
    begin
        if (cmd.push_start)
        begin
            stk_row_reg[0] <= scan_row_reg;
            stk_col_reg[0] <= scan_col_reg;
            stk_dir_reg[0] <= DIR_DOWN;
        end
        else if (cmd.push_nb)
        begin
            stk_row_reg[push_idx] <= nb_row_reg;
            stk_col_reg[push_idx] <= nb_col_reg;
            stk_dir_reg[push_idx] <= DIR_DOWN;
        end
        else if (cmd.step)
            stk_dir_reg[top_idx] <= dir_t'(top_dir + 3'd1);

        if (cmd.step)
        begin
            nb_row_reg <= nb_row;
            nb_col_reg <= nb_col;
        end
    end

    // ---------------- grid memory and word store ----------------
    assign load_ok = (int'(load_row) < MAX_ROWS) && (int'(load_col) < MAX_COLS);
    assign wr_addr = CELL_W'(int'(load_row) * MAX_COLS + int'(load_col));
    assign rd_addr = cmd.scan_read ?
                     CELL_W'(int'(scan_row_reg) * MAX_COLS + int'(scan_col_reg)) :
                     CELL_W'(int'(nb_row) * MAX_COLS + int'(nb_col));
    assign rd_en   = cmd.scan_read || cmd.step;

    always_ff @(posedge clk)
    begin
        if (cmd.load_grid && load_ok)
            grid_mem[wr_addr] <= load_char;
        if (rd_en)
            grid_rd_reg <= grid_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_word && (int'(load_position) < MAX_WORD))
            word_reg[DIDX_W'(load_position)] <= load_char;
    end

    // ---------------- status ----------------
    always_comb
    begin
        status.size_zero  = (rows_eff == '0) || (cols_eff == '0) || (len_eff == '0);
        status.scan_match = (grid_rd_reg == word_reg[0]);
        status.scan_last  = scan_row_last && scan_col_last;
        status.depth_hit  = (depth_reg >= len_eff);
        status.depth_zero = (depth_reg == '0);
        status.dir_done   = (top_dir == DIR_DONE);
        status.nb_ok      = nb_exists && !nb_visited;
        status.nb_match   = (grid_rd_reg == word_reg[push_idx]);
        status.out_full   = res_valid_reg && !result.ready;
    end

endmodule

// ----- src/gwps_ctrl.sv -----
`timescale 1ns / 1ps
// Controller: takes input beats, sequences the start-cell scan and the
// backtracking walk. Depends on gwps_pkg and gwps_if.
module gwps_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    gwps_item_if.sink         item,
    input  gwps_pkg::status_t status,
    output gwps_pkg::cmd_t    cmd
);
    import gwps_pkg::*;

    state_t state_reg, state_next;
    logic   accept;

    assign item.ready = (state_reg == ST_IDLE);
    assign accept     = item.valid && item.ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (item.kind == KIND_START))
                    state_next = status.size_zero ? ST_DONE_MISS : ST_SCAN_RD;
            end
            ST_SCAN_RD:
                state_next = ST_SCAN_CHK;
            ST_SCAN_CHK:
            begin
                if (status.scan_match)
                    state_next = ST_STEP;
                else if (status.scan_last)
                    state_next = ST_DONE_MISS;
                else
                    state_next = ST_SCAN_RD;
            end
            ST_STEP:
            begin
                if (status.depth_hit)
                    state_next = ST_DONE_HIT;
                else if (status.depth_zero)
                    state_next = status.scan_last ? ST_DONE_MISS : ST_SCAN_RD;
                else if (!status.dir_done && status.nb_ok)
                    state_next = ST_NB_CHK;
            end
            ST_NB_CHK:
                state_next = ST_STEP;
            ST_DONE_HIT, ST_DONE_MISS:
            begin
                if (!status.out_full)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.load_grid = (item.kind == KIND_GRID);
                    cmd.load_word = (item.kind == KIND_WORD);
                    cmd.scan_init = (item.kind == KIND_START);
                end
            end
            ST_SCAN_RD:
                cmd.scan_read = 1'b1;
            ST_SCAN_CHK:
            begin
                if (status.scan_match)
                    cmd.push_start = 1'b1;
                else if (!status.scan_last)
                    cmd.scan_next = 1'b1;
            end
            ST_STEP:
            begin
                if (status.depth_hit)
                    cmd.clear_depth = 1'b1;
                else if (status.depth_zero)
                    cmd.scan_next = !status.scan_last;
                else if (status.dir_done)
                    cmd.pop = 1'b1;
                else
                    cmd.step = 1'b1;
            end
            ST_NB_CHK:
                cmd.push_nb = status.nb_match;
            ST_DONE_HIT:
            begin
                cmd.post       = !status.out_full;
                cmd.post_found = 1'b1;
            end
            ST_DONE_MISS:
                cmd.post = !status.out_full;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ----- src/grid_word_path_search_core.sv -----
`timescale 1ns / 1ps
// Top level of the grid word path search core: controller plus datapath.
// Depends on gwps_pkg, gwps_if, gwps_ctrl and gwps_datapath.
//
//  channel  | dir | payload                                 | beat when
//  ---------+-----+-----------------------------------------+-------------------
//  item     | in  | kind, row, col, position, char_value    | valid && ready
//  result   | out | found                                   | valid && ready
//  cfg      | in  | index, data (grid_rows/grid_cols/len)   | valid && ready
//
//  Load beats are accepted one every cycle while the block is idle.
//  A start beat holds ready low until the search ends: each start cell is read and then
//  tested; in the walk a neighbor whose byte is read is compared in a second state, while
//  an out-of-area or visited direction, a pop, the final hit and the return to the scan
//  are each handled in the step state; then the result is posted once the register is free.
//  A pending result does not block loads or the next start; a finished search
//  waits only while the result register is still full.
//  rst_n clears the state machine, stack depth and registers (all sizes to 1).
module grid_word_path_search_core (
    input  logic       clk,
    input  logic       rst_n,
    gwps_item_if.sink  item,
    gwps_result_if.source result,
    gwps_cfg_if.sink   cfg
);
    import gwps_pkg::*;

    cmd_t    cmd;
    status_t status;

    gwps_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .status (status),
        .cmd    (cmd)
    );

    gwps_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .load_row      (item.row),
        .load_col      (item.col),
        .load_position (item.position),
        .load_char     (item.char_value),
        .cfg           (cfg),
        .result        (result)
    );

endmodule
